// ----- src/pbfs_pkg.sv -----
// Package for the packed bit field store.
// Holds field widths, the request mode codes, register indexes and reset values.
// Used by every module of the block; depends on nothing.
package pbfs_pkg;

	localparam int WORD_BITS = 64;
	localparam int OFF_W = $clog2(WORD_BITS);
	localparam int STORE_WORDS_DEF = 64;

	localparam int MODE_W = 3;
	localparam int IDX_W = 12;
	localparam int FW_W = 7;
	localparam int VS_W = 13;
	localparam int RW_W = 7;
	localparam int POS_W = IDX_W + RW_W;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = VS_W;

	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_WIDTH = 1'd1;

	localparam logic [VS_W-1:0] VECTOR_SIZE_RESET = 13'd4096;
	localparam logic [RW_W-1:0] RECORD_WIDTH_RESET = 7'd0;

	typedef enum logic [MODE_W-1:0] {
		MODE_SET          = 3'd0,
		MODE_CLEAR        = 3'd1,
		MODE_TEST         = 3'd2,
		MODE_READ_FIELD   = 3'd3,
		MODE_WRITE_FIELD  = 3'd4,
		MODE_READ_RECORD  = 3'd5,
		MODE_WRITE_RECORD = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_READ,
		ST_EXEC
	} state_t;

endpackage

// ----- src/pbfs_bank.sv -----
// One bank of the word store: a synchronous memory with one write port and
// one registered read port. Depends on pbfs_pkg for the word width.
module pbfs_bank #(
	parameter int DEPTH = pbfs_pkg::STORE_WORDS_DEF / 2,
	parameter int ADDR_W = $clog2(pbfs_pkg::STORE_WORDS_DEF / 2)
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [ADDR_W-1:0]              waddr,
	input  logic [pbfs_pkg::WORD_BITS-1:0] wdata,
	input  logic                           re,
	input  logic [ADDR_W-1:0]              raddr,
	output logic [pbfs_pkg::WORD_BITS-1:0] rdata
);

	logic [pbfs_pkg::WORD_BITS-1:0] mem [DEPTH];
	logic [pbfs_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/pbfs_field.sv -----
// Field extract and merge across a pair of adjacent words.
// Produces the read field and the updated low and high words for a write.
// Depends on pbfs_pkg for widths.
module pbfs_field (
	input  logic [pbfs_pkg::OFF_W-1:0]     off,
	input  logic [pbfs_pkg::FW_W-1:0]      width,
	input  logic [pbfs_pkg::WORD_BITS-1:0] wval,
	input  logic [pbfs_pkg::WORD_BITS-1:0] lo,
	input  logic [pbfs_pkg::WORD_BITS-1:0] hi,
	output logic                           straddle,
	output logic [pbfs_pkg::WORD_BITS-1:0] rdata,
	output logic [pbfs_pkg::WORD_BITS-1:0] new_lo,
	output logic [pbfs_pkg::WORD_BITS-1:0] new_hi
);

	logic [pbfs_pkg::WORD_BITS-1:0] mask;
	logic [pbfs_pkg::WORD_BITS-1:0] mval;
	logic [pbfs_pkg::FW_W-1:0]      sh;
	logic [pbfs_pkg::WORD_BITS-1:0] hi_part;

	always_comb begin
		if (width >= pbfs_pkg::FW_W'(pbfs_pkg::WORD_BITS)) begin
			mask = '1;
		end else begin
			mask = (pbfs_pkg::WORD_BITS'(1) << width) - pbfs_pkg::WORD_BITS'(1);
		end
		mval = wval & mask;
		straddle = ((pbfs_pkg::FW_W + 1)'(off) + (pbfs_pkg::FW_W + 1)'(width))
			> (pbfs_pkg::FW_W + 1)'(pbfs_pkg::WORD_BITS);
		sh = pbfs_pkg::FW_W'(pbfs_pkg::WORD_BITS) - pbfs_pkg::FW_W'(off);
		hi_part = straddle ? (hi << sh) : '0;
		rdata = ((lo >> off) | hi_part) & mask;
		new_lo = (lo & ~(mask << off)) | (mval << off);
		new_hi = (hi & ~(mask >> sh)) | (mval >> sh);
	end

endmodule

// ----- src/packed_bit_field_store_unit.sv -----
// Packed bit field store: set, clear or test a bit, or read and write fields and
// records of up to 64 bits at any bit offset, over a store split into even and
// odd word banks. An accepted item passes through the steps position multiply and
// range check, bank read, and merge and write back; its result is registered in
// the merge step, which waits while a previous result is still held unaccepted.
// The next item is accepted once the previous one has left the merge step, so
// items never overlap in the read, modify and write sequence on the banks. After
// reset a clearing pass zeroes the banks, during which no item is accepted.
// Depends on pbfs_pkg, pbfs_bank and pbfs_field.
module packed_bit_field_store_unit #(
	parameter int STORE_WORDS = pbfs_pkg::STORE_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pbfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbfs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pbfs_pkg::MODE_W-1:0]     mode,
	input  logic [pbfs_pkg::IDX_W-1:0]      bit_index,
	input  logic [pbfs_pkg::FW_W-1:0]       field_width,
	input  logic [pbfs_pkg::WORD_BITS-1:0]  write_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pbfs_pkg::WORD_BITS-1:0]  read_data,
	output logic [pbfs_pkg::VS_W-1:0]       next_index,
	output logic                            range_error
);

	localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
	localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int CAP_BITS = STORE_WORDS * pbfs_pkg::WORD_BITS;
	localparam int BASE_W = pbfs_pkg::POS_W - pbfs_pkg::OFF_W - 1;

	pbfs_pkg::state_t state_q, state_d;

	logic [pbfs_pkg::VS_W-1:0] vector_size_q;
	logic [pbfs_pkg::RW_W-1:0] record_width_q;
	logic [BANK_AW-1:0]        clr_cnt_q;

	logic [pbfs_pkg::MODE_W-1:0]    mode_q;
	logic [pbfs_pkg::IDX_W-1:0]     idx_q;
	logic [pbfs_pkg::FW_W-1:0]      fw_q;
	logic [pbfs_pkg::WORD_BITS-1:0] val_q;
	logic [pbfs_pkg::POS_W-1:0]     pos_q;
	logic [pbfs_pkg::FW_W-1:0]      w_q;
	logic                           err_q;
	logic                           acc_q;
	logic                           wr_q;
	logic [pbfs_pkg::VS_W-1:0]      next_q;

	logic                           out_valid_q;
	logic [pbfs_pkg::WORD_BITS-1:0] read_data_q;
	logic [pbfs_pkg::VS_W-1:0]      next_index_q;
	logic                           range_error_q;

	logic clr_we, rd_go, exec_fire, in_fire;

	logic [pbfs_pkg::VS_W-1:0]      size_c;
	logic [pbfs_pkg::POS_W-1:0]     rec_pos;
	logic [pbfs_pkg::POS_W:0]       rec_end;
	logic [pbfs_pkg::VS_W-1:0]      field_end;
	logic [pbfs_pkg::POS_W-1:0]     calc_pos;
	logic [pbfs_pkg::FW_W-1:0]      calc_w;
	logic                           calc_err;
	logic                           calc_wr;
	logic                           calc_rd;
	logic [pbfs_pkg::VS_W-1:0]      calc_next;
	logic [pbfs_pkg::WORD_BITS-1:0] calc_val;

	logic [BANK_AW-1:0]             base, base_inc;
	logic                           par;
	logic                           straddle;
	logic [pbfs_pkg::WORD_BITS-1:0] even_rd, odd_rd, lo, hi;
	logic [pbfs_pkg::WORD_BITS-1:0] f_rdata, new_lo, new_hi;
	logic                           exec_wr;
	logic                           even_we, odd_we, even_re, odd_re;
	logic [BANK_AW-1:0]             even_waddr, odd_waddr, even_raddr;
	logic [pbfs_pkg::WORD_BITS-1:0] even_wdata, odd_wdata;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pbfs_pkg::ST_CLEAR: begin
				if (clr_cnt_q == BANK_AW'(BANK_DEPTH - 1)) begin
					state_d = pbfs_pkg::ST_IDLE;
				end
			end
			pbfs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = pbfs_pkg::ST_CALC;
				end
			end
			pbfs_pkg::ST_CALC: state_d = pbfs_pkg::ST_READ;
			pbfs_pkg::ST_READ: state_d = pbfs_pkg::ST_EXEC;
			pbfs_pkg::ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_d = pbfs_pkg::ST_IDLE;
				end
			end
			default: state_d = pbfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		clr_we = 1'b0;
		rd_go = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			pbfs_pkg::ST_CLEAR: clr_we = 1'b1;
			pbfs_pkg::ST_IDLE:  in_ready = 1'b1;
			pbfs_pkg::ST_READ:  rd_go = 1'b1;
			pbfs_pkg::ST_EXEC:  exec_fire = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbfs_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
			vector_size_q <= pbfs_pkg::VECTOR_SIZE_RESET;
			record_width_q <= pbfs_pkg::RECORD_WIDTH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_cnt_q <= clr_cnt_q + BANK_AW'(1);
			end
			if (cfg_we) begin
				case (cfg_index)
					pbfs_pkg::REG_VECTOR_SIZE:  vector_size_q <= cfg_data;
					pbfs_pkg::REG_RECORD_WIDTH: record_width_q <= cfg_data[pbfs_pkg::RW_W-1:0];
					default: ;
				endcase
			end
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (32'(vector_size_q) < 32'(CAP_BITS)) begin
			size_c = vector_size_q;
		end else begin
			size_c = pbfs_pkg::VS_W'(CAP_BITS);
		end
		rec_pos = pbfs_pkg::POS_W'(idx_q) * pbfs_pkg::POS_W'(record_width_q);
		rec_end = (pbfs_pkg::POS_W + 1)'(rec_pos) + (pbfs_pkg::POS_W + 1)'(record_width_q);
		field_end = pbfs_pkg::VS_W'(idx_q) + pbfs_pkg::VS_W'(fw_q);

		calc_pos = pbfs_pkg::POS_W'(idx_q);
		calc_w = pbfs_pkg::FW_W'(1);
		calc_err = 1'b0;
		calc_wr = 1'b0;
		calc_rd = 1'b0;
		calc_next = '0;
		calc_val = val_q;
		case (pbfs_pkg::mode_t'(mode_q))
			pbfs_pkg::MODE_SET: begin
				calc_err = pbfs_pkg::VS_W'(idx_q) >= size_c;
				calc_wr = 1'b1;
				calc_val = pbfs_pkg::WORD_BITS'(1);
			end
			pbfs_pkg::MODE_CLEAR: begin
				calc_err = pbfs_pkg::VS_W'(idx_q) >= size_c;
				calc_wr = 1'b1;
				calc_val = '0;
			end
			pbfs_pkg::MODE_TEST: begin
				calc_err = pbfs_pkg::VS_W'(idx_q) >= size_c;
				calc_rd = 1'b1;
			end
			pbfs_pkg::MODE_READ_FIELD, pbfs_pkg::MODE_WRITE_FIELD: begin
				calc_w = fw_q;
				calc_err = (fw_q > pbfs_pkg::FW_W'(pbfs_pkg::WORD_BITS)) || (field_end > size_c);
				calc_wr = pbfs_pkg::mode_t'(mode_q) == pbfs_pkg::MODE_WRITE_FIELD;
				calc_rd = !calc_wr;
				calc_next = calc_wr ? field_end : '0;
			end
			pbfs_pkg::MODE_READ_RECORD, pbfs_pkg::MODE_WRITE_RECORD: begin
				calc_pos = rec_pos;
				calc_w = record_width_q;
				calc_err = (record_width_q == '0)
					|| (record_width_q > pbfs_pkg::RW_W'(pbfs_pkg::WORD_BITS))
					|| (rec_end > (pbfs_pkg::POS_W + 1)'(size_c));
				calc_wr = pbfs_pkg::mode_t'(mode_q) == pbfs_pkg::MODE_WRITE_RECORD;
				calc_rd = !calc_wr;
				calc_next = calc_wr ? (pbfs_pkg::VS_W'(idx_q) + pbfs_pkg::VS_W'(1)) : '0;
			end
			default: ;
		endcase
		if (calc_err) begin
			calc_wr = 1'b0;
			calc_rd = 1'b0;
			calc_next = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= mode;
			idx_q <= bit_index;
			fw_q <= field_width;
			val_q <= write_value;
		end else if (state_q == pbfs_pkg::ST_CALC) begin
			pos_q <= calc_pos;
			w_q <= calc_w;
			err_q <= calc_err;
			acc_q <= (calc_wr || calc_rd) && (calc_w != '0);
			wr_q <= calc_wr;
			next_q <= calc_next;
			val_q <= calc_val;
		end
	end

	assign base = BANK_AW'(pos_q[pbfs_pkg::POS_W-1:pbfs_pkg::OFF_W+1]);
	assign base_inc = BANK_AW'(pos_q[pbfs_pkg::POS_W-1:pbfs_pkg::OFF_W+1] + BASE_W'(1));
	assign par = pos_q[pbfs_pkg::OFF_W];

	pbfs_field u_field (
		.off     (pos_q[pbfs_pkg::OFF_W-1:0]),
		.width   (w_q),
		.wval    (val_q),
		.lo      (lo),
		.hi      (hi),
		.straddle(straddle),
		.rdata   (f_rdata),
		.new_lo  (new_lo),
		.new_hi  (new_hi)
	);

	assign lo = par ? odd_rd : even_rd;
	assign hi = par ? even_rd : odd_rd;
	assign exec_wr = exec_fire && acc_q && wr_q;

	assign even_re = rd_go && acc_q && (!par || straddle);
	assign odd_re = rd_go && acc_q && (par || straddle);
	assign even_raddr = par ? base_inc : base;

	assign even_we = clr_we || (exec_wr && (!par || straddle));
	assign odd_we = clr_we || (exec_wr && (par || straddle));
	assign even_waddr = clr_we ? clr_cnt_q : (par ? base_inc : base);
	assign odd_waddr = clr_we ? clr_cnt_q : base;
	assign even_wdata = clr_we ? '0 : (par ? new_hi : new_lo);
	assign odd_wdata = clr_we ? '0 : (par ? new_lo : new_hi);

	pbfs_bank #(
		.DEPTH (BANK_DEPTH),
		.ADDR_W(BANK_AW)
	) u_even_bank (
		.clk  (clk),
		.we   (even_we),
		.waddr(even_waddr),
		.wdata(even_wdata),
		.re   (even_re),
		.raddr(even_raddr),
		.rdata(even_rd)
	);

	pbfs_bank #(
		.DEPTH (BANK_DEPTH),
		.ADDR_W(BANK_AW)
	) u_odd_bank (
		.clk  (clk),
		.we   (odd_we),
		.waddr(odd_waddr),
		.wdata(odd_wdata),
		.re   (odd_re),
		.raddr(base),
		.rdata(odd_rd)
	);

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			read_data_q <= (acc_q && !wr_q) ? f_rdata : '0;
			next_index_q <= next_q;
			range_error_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign next_index = next_index_q;
	assign range_error = range_error_q;

endmodule
